@@ rtl/gdec_pkg.sv @@
// Shared types, constants and the genotype code table for the packed genotype row decoder.
`timescale 1ns / 1ps

package gdec_pkg;

   localparam int ROW_REG_W       = 21;
   localparam int IDX_W           = 20;
   localparam int PAIRS_PER_BYTE  = 4;
   localparam int MAX_INDIVIDUALS_DEFAULT = 1048576;
   localparam int REQ_DATA_W      = 16;
   localparam int RSP_DATA_W      = 24;

   // Two-bit codes as they appear in a packed byte.
   localparam logic [1:0] CODE_HOM_FIRST  = 2'b00;
   localparam logic [1:0] CODE_MISSING    = 2'b01;
   localparam logic [1:0] CODE_HET        = 2'b10;
   localparam logic [1:0] CODE_HOM_SECOND = 2'b11;

   // Genotype values carried in a result word.
   localparam logic [1:0] GENO_HOM_FIRST  = 2'd0;
   localparam logic [1:0] GENO_HET        = 2'd1;
   localparam logic [1:0] GENO_HOM_SECOND = 2'd2;

   typedef struct packed {
      logic             is_missing;
      logic [1:0]       genotype;
      logic [IDX_W-1:0] sample_index;
      logic             last_of_byte;
      logic             row_end;
   } result_type;

   typedef struct packed {
      logic [PAIRS_PER_BYTE-1:0] valid;
      result_type [PAIRS_PER_BYTE-1:0] slot;
   } byte_result_type;

   // A missing code reports genotype zero.
   function automatic logic [1:0] decode_genotype(input logic [1:0] code);
      logic [1:0] geno;
      unique case (code)
         CODE_HOM_FIRST:  geno = GENO_HOM_FIRST;
         CODE_HET:        geno = GENO_HET;
         CODE_HOM_SECOND: geno = GENO_HOM_SECOND;
         default:         geno = GENO_HOM_FIRST;
      endcase
      return geno;
   endfunction

endpackage

@@ rtl/gdec_decode.sv @@
// Combinational decode of one packed byte into up to four result slots and next counters.
`timescale 1ns / 1ps

module gdec_decode #(
   parameter int CNT_W = 21
) (
   input  logic [CNT_W-1:0]           row_len,
   input  logic [CNT_W-1:0]           seen,
   input  logic [CNT_W-1:0]           included,
   input  logic [CNT_W-1:0]           present,
   input  logic [7:0]                 packed_byte,
   input  logic [3:0]                 include_flags,
   output gdec_pkg::byte_result_type  result,
   output logic [CNT_W-1:0]           seen_next,
   output logic [CNT_W-1:0]           included_next,
   output logic [CNT_W-1:0]           present_next
);

   logic             guard;
   logic [CNT_W-1:0] s_eff;
   logic [CNT_W-1:0] i_eff;
   logic [CNT_W-1:0] p_eff;
   logic [CNT_W-1:0] left;
   logic [2:0]       pairs;
   logic             ends;
   logic [3:0]       active;
   logic [2:0]       inc_off;
   logic [2:0]       pres_off;
   logic [1:0]       code;
   logic             miss;

   always_comb begin
      // A seen count at or past the row length starts a fresh row.
      guard = (seen >= row_len);
      s_eff = guard ? '0 : seen;
      i_eff = guard ? '0 : included;
      p_eff = guard ? '0 : present;

      left  = row_len - s_eff;
      pairs = (left < CNT_W'(gdec_pkg::PAIRS_PER_BYTE)) ? left[2:0]
                                                        : 3'(gdec_pkg::PAIRS_PER_BYTE);
      ends  = (left <= CNT_W'(gdec_pkg::PAIRS_PER_BYTE));

      inc_off  = '0;
      pres_off = '0;
      active   = '0;
      code     = '0;
      miss     = 1'b0;
      for (int k = 0; k < gdec_pkg::PAIRS_PER_BYTE; k++) begin
         code      = packed_byte[2*k +: 2];
         miss      = (code == gdec_pkg::CODE_MISSING);
         active[k] = include_flags[k] && (3'(k) < pairs);
         result.slot[k].is_missing   = miss;
         result.slot[k].genotype     = gdec_pkg::decode_genotype(code);
         result.slot[k].sample_index = miss ?
            gdec_pkg::IDX_W'(i_eff + CNT_W'(inc_off)) :
            gdec_pkg::IDX_W'(p_eff + CNT_W'(pres_off));
         result.slot[k].row_end      = ends;
         if (active[k]) begin
            inc_off = inc_off + 3'd1;
            if (!miss) begin
               pres_off = pres_off + 3'd1;
            end
         end
      end

      // The highest active slot carries the end-of-byte mark.
      for (int k = 0; k < gdec_pkg::PAIRS_PER_BYTE; k++) begin
         result.slot[k].last_of_byte = active[k] && ((active >> (k + 1)) == 4'd0);
      end
      result.valid = active;

      if (ends) begin
         seen_next     = '0;
         included_next = '0;
         present_next  = '0;
      end else begin
         seen_next     = s_eff + CNT_W'(pairs);
         included_next = i_eff + CNT_W'(inc_off);
         present_next  = p_eff + CNT_W'(pres_off);
      end
   end

endmodule

@@ rtl/gdec_serializer.sv @@
// Slot buffer for one decoded byte; the result register sends one slot per ready cycle.
`timescale 1ns / 1ps

module gdec_serializer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  gdec_pkg::byte_result_type  load_data,
   output logic                       load_ready,
   output logic                       rsp_valid,
   output gdec_pkg::result_type       rsp_data,
   input  logic                       rsp_ready
);

   logic [3:0]                 pend_ff;
   logic [3:0]                 pend_in;
   gdec_pkg::result_type [3:0] slot_ff;
   gdec_pkg::result_type [3:0] slot_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   gdec_pkg::result_type       rsp_data_ff;
   gdec_pkg::result_type       rsp_data_in;
   logic                       out_free;
   logic                       move;
   logic [3:0]                 pick;
   logic [3:0]                 pend_left;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      move     = out_free && (pend_ff != 4'd0);
      pick     = pend_ff & (~pend_ff + 4'd1);
      pend_left = move ? (pend_ff & ~pick) : pend_ff;
      load_ready = (pend_left == 4'd0);

      rsp_data_in = rsp_data_ff;
      for (int k = 0; k < gdec_pkg::PAIRS_PER_BYTE; k++) begin
         if (pick[k]) begin
            rsp_data_in = slot_ff[k];
         end
      end
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      pend_in = load ? load_data.valid : pend_left;
      slot_in = load ? load_data.slot : slot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff     <= slot_in;
      rsp_data_ff <= move ? rsp_data_in : rsp_data_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/packed_genotype_row_decoder_core.sv @@
// Top level of the packed genotype row decoder: register, row counters, decode and output.
`timescale 1ns / 1ps

// Channel    | Direction | Handshake               | Contents
// req_       | in        | req_tvalid / req_tready | one packed byte plus four include flags
// rsp_       | out       | rsp_tvalid / rsp_tready | one decoded genotype or missing record
// csr_       | in        | csr_we                  | individuals_per_row
//
// A byte is decoded in the cycle it is accepted and its results are captured in a
// four-slot buffer; the result register then drains one slot per cycle while
// rsp_tready allows. The next byte is accepted as the last pending slot moves into
// the result register, so a full byte is limited by the single result register.
// Reset is synchronous and active high: it clears the counters, empties the buffer and
// sets the row length to one. A stalled rsp_tready holds the result word and, once the
// buffer holds more than the word in flight, holds req_tready low.

module packed_genotype_row_decoder_core #(
   parameter int MAX_INDIVIDUALS = gdec_pkg::MAX_INDIVIDUALS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request words.
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [7:0] packed_byte, [11:8] include_flags, [15:12] zero
   input  logic [gdec_pkg::REQ_DATA_W-1:0] req_tdata,
   // Result words.
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] genotype, [21:2] sample_index, [22] row_end, [23] zero
   output logic [gdec_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,   // last_of_byte
   // [0] is_missing
   output logic                            rsp_tuser,
   // Row length register.
   input  logic                            csr_we,
   input  logic [gdec_pkg::ROW_REG_W-1:0]  csr_wdata
);

   // Counters must hold the largest row length itself.
   localparam int CNT_W = $clog2(MAX_INDIVIDUALS + 1);
   localparam int LEN_W = (CNT_W > gdec_pkg::ROW_REG_W) ? CNT_W : gdec_pkg::ROW_REG_W;

   logic [gdec_pkg::ROW_REG_W-1:0] row_reg_ff;
   logic [gdec_pkg::ROW_REG_W-1:0] row_reg_in;
   logic [CNT_W-1:0]               seen_ff;
   logic [CNT_W-1:0]               seen_in;
   logic [CNT_W-1:0]               included_ff;
   logic [CNT_W-1:0]               included_in;
   logic [CNT_W-1:0]               present_ff;
   logic [CNT_W-1:0]               present_in;
   logic [CNT_W-1:0]               seen_next;
   logic [CNT_W-1:0]               included_next;
   logic [CNT_W-1:0]               present_next;
   logic [LEN_W-1:0]               len_wide;
   logic [CNT_W-1:0]               row_len;
   logic                           req_accept;
   logic                           buf_ready;
   gdec_pkg::byte_result_type      decoded;
   gdec_pkg::result_type           rsp_word;

   // A zero length acts as a row of one; lengths beyond the maximum are clamped.
   always_comb begin
      len_wide = LEN_W'(row_reg_ff);
      if (len_wide == '0) begin
         len_wide = LEN_W'(1);
      end else if (len_wide > LEN_W'(MAX_INDIVIDUALS)) begin
         len_wide = LEN_W'(MAX_INDIVIDUALS);
      end
      row_len = CNT_W'(len_wide);
   end

   assign req_tready = buf_ready;
   assign req_accept = req_tvalid && buf_ready;

   gdec_decode #(
      .CNT_W (CNT_W)
   ) u_decode (
      .row_len       (row_len),
      .seen          (seen_ff),
      .included      (included_ff),
      .present       (present_ff),
      .packed_byte   (req_tdata[7:0]),
      .include_flags (req_tdata[11:8]),
      .result        (decoded),
      .seen_next     (seen_next),
      .included_next (included_next),
      .present_next  (present_next)
   );

   // Writing the row length also starts a new row with the next byte.
   always_comb begin
      row_reg_in  = row_reg_ff;
      seen_in     = seen_ff;
      included_in = included_ff;
      present_in  = present_ff;
      if (csr_we) begin
         row_reg_in  = csr_wdata;
         seen_in     = '0;
         included_in = '0;
         present_in  = '0;
      end else if (req_accept) begin
         seen_in     = seen_next;
         included_in = included_next;
         present_in  = present_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_reg_ff  <= gdec_pkg::ROW_REG_W'(1);
         seen_ff     <= '0;
         included_ff <= '0;
         present_ff  <= '0;
      end else begin
         row_reg_ff  <= row_reg_in;
         seen_ff     <= seen_in;
         included_ff <= included_in;
         present_ff  <= present_in;
      end
   end

   gdec_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .load_data  (decoded),
      .load_ready (buf_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_data   (rsp_word),
      .rsp_ready  (rsp_tready)
   );

   assign rsp_tdata = {1'b0, rsp_word.row_end, rsp_word.sample_index, rsp_word.genotype};
   assign rsp_tlast = rsp_word.last_of_byte;
   assign rsp_tuser = rsp_word.is_missing;

`ifndef ASSERT_OFF
   // Present individuals are a subset of included ones.
   a_present_le_included: assert property (@(posedge clock) disable iff (reset)
      present_ff <= included_ff)
      else $error("present count exceeds included count");

   // Included individuals are a subset of those consumed in the row.
   a_included_le_seen: assert property (@(posedge clock) disable iff (reset)
      included_ff <= seen_ff)
      else $error("included count exceeds seen count");

   // A row in progress never reaches its length; the final byte clears the counters.
   a_seen_below_len: assert property (@(posedge clock) disable iff (reset)
      seen_ff < row_len)
      else $error("seen count reached the row length");

   // A missing record always reports genotype zero.
   a_missing_geno_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[1:0] == gdec_pkg::GENO_HOM_FIRST)
      else $error("missing record with nonzero genotype");
`endif

endmodule

@@ sim/packed_genotype_row_decoder_core_test.sv @@
// Self-checking testbench for the packed genotype row decoder core.
`timescale 1ns / 1ps

module packed_genotype_row_decoder_core_test;

   import gdec_pkg::*;

   localparam int unsigned ROW_LIMIT      = MAX_INDIVIDUALS_DEFAULT;
   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          SETTLE_CYCLES  = 8;
   localparam int          BYTES_PER_ROW_SETTING = 22;

   typedef enum logic {STEP_BYTE, STEP_CSR} step_kind_type;
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_type;

   // One line of the directed table. A typed line carries its expected record
   // (at most one); every other line is checked against the row decoder model.
   typedef struct {
      step_kind_type          kind;
      logic [ROW_REG_W-1:0]   row_length;
      logic [7:0]             packed_byte;
      logic [3:0]             include_flags;
      bit                     typed;
      int                     exp_count;
      result_type             exp_rec;
   } directed_step_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    rsp_tuser;
   logic                    csr_we = 1'b0;
   logic [ROW_REG_W-1:0]    csr_wdata = '0;

   // Model state: the row length register and the three row counters.
   logic [ROW_REG_W-1:0]    row_length_reg  = 21'd1;
   logic [ROW_REG_W-1:0]    seen_in_row     = '0;
   logic [ROW_REG_W-1:0]    included_in_row = '0;
   logic [ROW_REG_W-1:0]    present_in_row  = '0;

   result_type              pending_records[$];
   int                      fail_count      = 0;
   int                      records_checked = 0;
   int                      burst_left      = 0;
   int                      idle_cycles     = 0;

   // Receiver pattern state.
   rx_mode_type             rx_mode         = RX_OPEN;
   int                      rx_phase_left   = 0;
   int                      hold_left       = 0;
   bit                      hold_done       = 1'b0;

   localparam result_type REC_ZERO_ONLY = '{1'b0, GENO_HOM_FIRST, 20'd0, 1'b1, 1'b1};
   localparam result_type REC_HET_ONLY  = '{1'b0, GENO_HET, 20'd0, 1'b1, 1'b1};
   localparam result_type REC_HOM2_ONLY = '{1'b0, GENO_HOM_SECOND, 20'd0, 1'b1, 1'b1};
   localparam result_type REC_MISS_ONLY = '{1'b1, GENO_HOM_FIRST, 20'd0, 1'b1, 1'b1};

   // Directed part. After reset the row length is one, so each byte decodes only
   // its low pair and every record has index zero, row_end and last_of_byte set.
   directed_step_type directed_steps[23] = '{
      '{STEP_BYTE, 21'd0,       8'h00, 4'h1, 1'b1, 1, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'h02, 4'h1, 1'b1, 1, REC_HET_ONLY},
      // Flags of pairs past the row end are ignored.
      '{STEP_BYTE, 21'd0,       8'h03, 4'hF, 1'b1, 1, REC_HOM2_ONLY},
      '{STEP_BYTE, 21'd0,       8'h01, 4'h1, 1'b1, 1, REC_MISS_ONLY},
      // Last pair excluded: the row ends silently.
      '{STEP_BYTE, 21'd0,       8'hFF, 4'hE, 1'b1, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'hFC, 4'h1, 1'b1, 1, REC_ZERO_ONLY},
      '{STEP_CSR,  21'd4,       8'h00, 4'h0, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'hE4, 4'hF, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'h00, 4'h0, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'hFF, 4'hA, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_CSR,  21'd5,       8'h00, 4'h0, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'h1B, 4'hF, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'hFF, 4'hF, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'h55, 4'hF, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'hAA, 4'h5, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'h00, 4'hE, 1'b0, 0, REC_ZERO_ONLY},
      // A zero row length behaves as a row of one.
      '{STEP_CSR,  21'd0,       8'h00, 4'h0, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'h03, 4'h1, 1'b1, 1, REC_HOM2_ONLY},
      '{STEP_BYTE, 21'd0,       8'h01, 4'h1, 1'b1, 1, REC_MISS_ONLY},
      // Register maximum is clamped to the largest supported row.
      '{STEP_CSR,  21'h1FFFFF,  8'h00, 4'h0, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'hE4, 4'hF, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_CSR,  21'd1048576, 8'h00, 4'h0, 1'b0, 0, REC_ZERO_ONLY},
      '{STEP_BYTE, 21'd0,       8'h55, 4'hF, 1'b0, 0, REC_ZERO_ONLY}
   };

   logic [ROW_REG_W-1:0] row_settings[11] = '{
      21'd0, 21'd1, 21'd2, 21'd3, 21'd4, 21'd6, 21'd7, 21'd13,
      21'd1048576, 21'h1FFFFF, 21'd1
   };

   packed_genotype_row_decoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic log_failure(input string msg);
      if (fail_count < 10) begin
         $display("ERROR: %s", msg);
      end
      fail_count++;
   endtask

   // Decodes one accepted byte against the row counters and, when asked,
   // queues the records it yields.
   task automatic decode_row_byte(input logic [7:0] packed_byte,
                                  input logic [3:0] include_flags,
                                  input bit         queue_records);
      int unsigned row_len;
      int unsigned left;
      int unsigned pairs;
      int          count;
      bit          ends;
      logic [1:0]  code;
      result_type  recs[PAIRS_PER_BYTE];
      row_len = (row_length_reg == '0) ? 1 : int'(row_length_reg);
      if (row_len > ROW_LIMIT) begin
         row_len = ROW_LIMIT;
      end
      if (int'(seen_in_row) >= row_len) begin
         seen_in_row = '0;
         included_in_row = '0;
         present_in_row = '0;
      end
      left  = row_len - int'(seen_in_row);
      pairs = (left < PAIRS_PER_BYTE) ? left : PAIRS_PER_BYTE;
      ends  = (left <= PAIRS_PER_BYTE);
      count = 0;
      for (int k = 0; k < int'(pairs); k++) begin
         code = packed_byte[2*k +: 2];
         if (!include_flags[k]) begin
            continue;
         end
         recs[count] = '0;
         if (code == CODE_MISSING) begin
            recs[count].is_missing   = 1'b1;
            recs[count].genotype     = GENO_HOM_FIRST;
            recs[count].sample_index = included_in_row[IDX_W-1:0];
         end else begin
            recs[count].genotype = (code == CODE_HOM_FIRST) ? GENO_HOM_FIRST :
                                   (code == CODE_HET)       ? GENO_HET : GENO_HOM_SECOND;
            recs[count].sample_index = present_in_row[IDX_W-1:0];
            present_in_row++;
         end
         recs[count].row_end = ends;
         included_in_row++;
         count++;
      end
      if (count > 0) begin
         recs[count-1].last_of_byte = 1'b1;
      end
      if (ends) begin
         seen_in_row = '0;
         included_in_row = '0;
         present_in_row = '0;
      end else begin
         seen_in_row = seen_in_row + ROW_REG_W'(pairs);
      end
      if (queue_records) begin
         for (int j = 0; j < count; j++) begin
            pending_records.push_back(recs[j]);
         end
      end
   endtask

   // Offers one byte in the sender's burst pattern and waits for the handshake.
   task automatic offer_byte(input logic [7:0] packed_byte,
                             input logic [3:0] include_flags,
                             input bit         queue_records);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 10);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, include_flags, packed_byte};
      do @(posedge clock); while (!req_tready);
      decode_row_byte(packed_byte, include_flags, queue_records);
   endtask

   // The row length may change only with the decoder drained: all records
   // back, plus a few cycles for a byte that produced nothing.
   task automatic write_row_length(input logic [ROW_REG_W-1:0] value);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      row_length_reg  = value;
      seen_in_row     = '0;
      included_in_row = '0;
      present_in_row  = '0;
   endtask

   // Result side: check each accepted word, then pick the next ready level.
   always @(posedge clock) begin
      result_type exp_rec;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            records_checked++;
            if (pending_records.size() == 0) begin
               log_failure($sformatf("unexpected word: missing=%0b geno=%0d idx=%0d last=%0b end=%0b",
                  rsp_tuser, rsp_tdata[1:0], rsp_tdata[21:2], rsp_tlast, rsp_tdata[22]));
            end else begin
               exp_rec = pending_records.pop_front();
               if (rsp_tuser !== exp_rec.is_missing || rsp_tdata[1:0] !== exp_rec.genotype ||
                   rsp_tdata[21:2] !== exp_rec.sample_index ||
                   rsp_tlast !== exp_rec.last_of_byte || rsp_tdata[22] !== exp_rec.row_end) begin
                  log_failure($sformatf({"word %0d: expected missing=%0b geno=%0d idx=%0d ",
                     "last=%0b end=%0b, got missing=%0b geno=%0d idx=%0d last=%0b end=%0b"},
                     records_checked, exp_rec.is_missing, exp_rec.genotype,
                     exp_rec.sample_index, exp_rec.last_of_byte, exp_rec.row_end,
                     rsp_tuser, rsp_tdata[1:0], rsp_tdata[21:2], rsp_tlast, rsp_tdata[22]));
               end
            end
         end
         // Once, well into the run, hold off long enough to back up the input.
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!hold_done && records_checked >= 100) begin
            hold_done = 1'b1;
            hold_left = 80;
            rsp_tready <= 1'b0;
         end else begin
            if (rx_phase_left == 0) begin
               rx_mode = rx_mode_type'($urandom_range(0, 3));
               rx_phase_left = $urandom_range(10, 60);
            end
            rx_phase_left--;
            case (rx_mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
               default:   rsp_tready <= ~rsp_tready;
            endcase
         end
      end
   end

   // Watchdog on cycles in which neither channel nor the register moves.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      logic [7:0] rand_byte;
      logic [3:0] rand_flags;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR) begin
            write_row_length(directed_steps[i].row_length);
         end else begin
            offer_byte(directed_steps[i].packed_byte, directed_steps[i].include_flags,
                       !directed_steps[i].typed);
            if (directed_steps[i].typed) begin
               for (int j = 0; j < directed_steps[i].exp_count; j++) begin
                  pending_records.push_back(directed_steps[i].exp_rec);
               end
            end
         end
      end

      // Random part: a run of bytes under each row length, one random length last.
      for (int s = 0; s <= $size(row_settings); s++) begin
         write_row_length((s < $size(row_settings)) ? row_settings[s]
                                                    : 21'($urandom_range(1, 40)));
         for (int n = 0; n < BYTES_PER_ROW_SETTING; n++) begin
            case ($urandom_range(0, 9))
               0:       rand_byte = 8'h55;
               1:       rand_byte = 8'hAA;
               default: rand_byte = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 9))
               0:          rand_flags = 4'h0;
               1, 2, 3:    rand_flags = 4'($urandom_range(0, 15));
               default:    rand_flags = 4'hF;
            endcase
            offer_byte(rand_byte, rand_flags, 1'b1);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_records.size() != 0) begin
         log_failure($sformatf("%0d expected words never arrived", pending_records.size()));
      end
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ packed_genotype_row_decoder_core.f @@
rtl/gdec_pkg.sv
rtl/gdec_decode.sv
rtl/gdec_serializer.sv
rtl/packed_genotype_row_decoder_core.sv
sim/packed_genotype_row_decoder_core_test.sv
